// File: hdl/mppt_duty_tracker_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef MPPT_DUTY_TRACKER_DEFINES_SVH
`define MPPT_DUTY_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define MDT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mppt_duty_tracker: same-cycle check failed");
`define MDT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mppt_duty_tracker: next-cycle check failed");
`else
`define MDT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MDT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/mdt_pkg.sv
// Package with types, constants and width helpers of the MPPT duty tracker.
`timescale 1ns / 1ps

package mdt_pkg;

  localparam int ADC_BITS_DEFAULT    = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int FRAC_BITS           = 16;
  localparam int GAIN_W              = 16;
  localparam int OFFSET_W            = 22;
  localparam int DUTY_W              = 16;
  localparam int PERIOD_W            = 10;
  localparam int CFG_INDEX_W         = 4;
  localparam int CFG_DATA_W          = 22;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRACKING_MODE  = 4'd0,
    CFG_VOLTAGE_GAIN   = 4'd1,
    CFG_CURRENT_GAIN   = 4'd2,
    CFG_CURRENT_OFFSET = 4'd3,
    CFG_DUTY_STEP      = 4'd4,
    CFG_DUTY_CEILING   = 4'd5,
    CFG_DUTY_FLOOR     = 4'd6,
    CFG_PWM_PERIOD     = 4'd7
  } cfg_index_t;

  typedef struct packed {
    logic                tracking_mode;
    logic [GAIN_W-1:0]   voltage_gain;
    logic [GAIN_W-1:0]   current_gain;
    logic [OFFSET_W-1:0] current_offset;
    logic [DUTY_W-1:0]   duty_step;
    logic [DUTY_W-1:0]   duty_ceiling;
    logic [DUTY_W-1:0]   duty_floor;
    logic [PERIOD_W-1:0] pwm_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tracking_mode:  1'b0,
    voltage_gain:   16'd4164,
    current_gain:   16'd3203,
    current_offset: 22'd1638400,
    duty_step:      16'd655,
    duty_ceiling:   16'd55706,
    duty_floor:     16'd0,
    pwm_period:     10'd159
  };

  typedef enum logic [1:0] {
    MOVE_HOLD = 2'd0,
    MOVE_UP   = 2'd1,
    MOVE_DOWN = 2'd2
  } move_t;

  typedef struct packed {
    logic dv_pos;
    logic dv_zero;
    logic di_pos;
    logic di_zero;
  } delta_class_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] duty_count;
    logic [DUTY_W-1:0]   duty_fraction;
    move_t               move;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_P,
    BK_MUL_A,
    BK_MUL_B,
    BK_DECIDE,
    BK_STEP,
    BK_MUL_D,
    BK_EMIT
  } back_state_t;

  function automatic int volt_w(input int adc_bits);
    return adc_bits + GAIN_W;
  endfunction

  function automatic int curr_w(input int adc_bits);
    return adc_bits + GAIN_W + 2;
  endfunction

  function automatic int entry_w(input int adc_bits);
    return 2 * volt_w(adc_bits) + 2 * curr_w(adc_bits) + 2 + $bits(delta_class_t);
  endfunction

endpackage

// File: hdl/mdt_fifo.sv
// Small register queue with show-ahead read.
`timescale 1ns / 1ps

module mdt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/mdt_front.sv
// Front end: accept samples, scale them, form and classify the deltas.
`timescale 1ns / 1ps

module mdt_front #(
  parameter int ADC_BITS = mdt_pkg::ADC_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mdt_pkg::cfg_t                          cfg,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [ADC_BITS-1:0]                    in_voltage_code,
  input  logic [ADC_BITS-1:0]                    in_current_code,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [mdt_pkg::entry_w(ADC_BITS)-1:0] q_wdata
);

  localparam int VOLT_W = mdt_pkg::volt_w(ADC_BITS);
  localparam int CURR_W = mdt_pkg::curr_w(ADC_BITS);
  localparam int DV_W   = VOLT_W + 1;
  localparam int DI_W   = CURR_W + 1;

  logic                     s1_valid_r;
  logic [ADC_BITS-1:0]      vcode_r, icode_r;
  logic                     s2_valid_r;
  logic [VOLT_W-1:0]        volt_r, volt_nxt;
  logic signed [CURR_W-1:0] curr_r, curr_nxt;
  logic [VOLT_W-1:0]        last_volt_r;
  logic signed [CURR_W-1:0] last_curr_r;
  logic [VOLT_W-1:0]        iprod;
  logic signed [DV_W-1:0]   dv;
  logic signed [DI_W-1:0]   di;
  mdt_pkg::delta_class_t    cls;
  logic                     s2_go, s2_free, s1_go, s1_free, accept;

  assign s2_go   = s2_valid_r && !q_full;
  assign s2_free = !s2_valid_r || s2_go;
  assign s1_go   = s1_valid_r && s2_free;
  assign s1_free = !s1_valid_r || s1_go;
  assign in_full = !s1_free;
  assign accept  = in_push && !in_full;
  assign q_push  = s2_go;

  assign volt_nxt = VOLT_W'(vcode_r) * VOLT_W'(cfg.voltage_gain);
  assign iprod    = VOLT_W'(icode_r) * VOLT_W'(cfg.current_gain);
  assign curr_nxt = CURR_W'(cfg.current_offset) - CURR_W'(iprod);

  assign dv = DV_W'(volt_r) - DV_W'(last_volt_r);
  assign di = DI_W'(curr_r) - DI_W'(last_curr_r);

  assign cls.dv_pos  = !dv[DV_W-1] && (dv != '0);
  assign cls.dv_zero = (dv == '0);
  assign cls.di_pos  = !di[DI_W-1] && (di != '0);
  assign cls.di_zero = (di == '0);

  assign q_wdata = {volt_r, curr_r, dv, di, cls};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      last_volt_r <= '0;
      last_curr_r <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= accept;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_go) begin
        last_volt_r <= volt_r;
        last_curr_r <= curr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vcode_r <= in_voltage_code;
      icode_r <= in_current_code;
    end
    if (s1_go) begin
      volt_r <= volt_nxt;
      curr_r <= curr_nxt;
    end
  end

endmodule

// File: hdl/mdt_back.sv
// Back end: sequencer with one shared multiplier for power, the decision's cross products and the PWM count.
`timescale 1ns / 1ps

module mdt_back #(
  parameter int ADC_BITS = mdt_pkg::ADC_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mdt_pkg::cfg_t                          cfg,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic [mdt_pkg::entry_w(ADC_BITS)-1:0] q_rdata,
  input  logic                                   out_full,
  output logic                                   out_push,
  output mdt_pkg::result_t                       out_result
);

  localparam int VOLT_W   = mdt_pkg::volt_w(ADC_BITS);
  localparam int CURR_W   = mdt_pkg::curr_w(ADC_BITS);
  localparam int DV_W     = VOLT_W + 1;
  localparam int DI_W     = CURR_W + 1;
  localparam int CLS_W    = $bits(mdt_pkg::delta_class_t);
  localparam int DI_LSB   = CLS_W;
  localparam int DV_LSB   = DI_LSB + DI_W;
  localparam int CURR_LSB = DV_LSB + DV_W;
  localparam int VOLT_LSB = CURR_LSB + CURR_W;
  localparam int A_W      = DI_W;
  localparam int B_W      = DV_W;
  localparam int PROD_W   = A_W + B_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int POW_W    = VOLT_W + CURR_W;
  localparam int STEP_W   = mdt_pkg::DUTY_W + 2;

  mdt_pkg::back_state_t        state_r, state_nxt;
  logic [VOLT_W-1:0]           volt_r;
  logic signed [CURR_W-1:0]    curr_r;
  logic signed [DV_W-1:0]      dv_r;
  logic signed [DI_W-1:0]      di_r;
  mdt_pkg::delta_class_t       cls_r;
  logic signed [A_W-1:0]       op_a;
  logic signed [B_W-1:0]       op_b;
  logic                        mul_en;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [PROD_W-1:0]    acc_r;
  logic signed [POW_W-1:0]     pwr_r, last_pwr_r;
  logic signed [POW_W:0]       dp;
  logic                        dp_pos, dp_pos_r;
  logic signed [SUM_W-1:0]     sum;
  logic                        sum_pos, sum_neg, go_up, go_down;
  mdt_pkg::move_t              move_r, move_nxt;
  logic signed [STEP_W-1:0]    base, step, stepped, ceil_s, floor_s;
  logic [mdt_pkg::DUTY_W-1:0]  duty_now_r, duty_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdt_pkg::BK_IDLE:   if (!q_empty) state_nxt = mdt_pkg::BK_MUL_P;
      mdt_pkg::BK_MUL_P:  state_nxt = mdt_pkg::BK_MUL_A;
      mdt_pkg::BK_MUL_A:  state_nxt = mdt_pkg::BK_MUL_B;
      mdt_pkg::BK_MUL_B:  state_nxt = mdt_pkg::BK_DECIDE;
      mdt_pkg::BK_DECIDE: state_nxt = mdt_pkg::BK_STEP;
      mdt_pkg::BK_STEP:   state_nxt = mdt_pkg::BK_MUL_D;
      mdt_pkg::BK_MUL_D:  state_nxt = mdt_pkg::BK_EMIT;
      mdt_pkg::BK_EMIT:   if (!out_full) state_nxt = mdt_pkg::BK_IDLE;
      default:            state_nxt = mdt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_push = 1'b0;
    mul_en   = 1'b0;
    op_a     = A_W'(curr_r);
    op_b     = B_W'(volt_r);
    case (state_r)
      mdt_pkg::BK_IDLE: begin
        q_pop = !q_empty;
      end
      mdt_pkg::BK_MUL_P: begin
        mul_en = 1'b1;
      end
      mdt_pkg::BK_MUL_A: begin
        mul_en = 1'b1;
        op_a   = di_r;
      end
      mdt_pkg::BK_MUL_B: begin
        mul_en = 1'b1;
        op_b   = dv_r;
      end
      mdt_pkg::BK_MUL_D: begin
        mul_en = 1'b1;
        op_a   = A_W'(duty_now_r);
        op_b   = B_W'(cfg.pwm_period);
      end
      mdt_pkg::BK_EMIT: begin
        out_push = !out_full;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  assign dp     = (POW_W + 1)'(pwr_r) - (POW_W + 1)'(last_pwr_r);
  assign dp_pos = !dp[POW_W] && (dp != '0);

  assign sum     = SUM_W'(acc_r) + SUM_W'(prod_r);
  assign sum_pos = !sum[SUM_W-1] && (sum != '0);
  assign sum_neg = sum[SUM_W-1];

  always_comb begin
    go_up   = 1'b0;
    go_down = 1'b0;
    if (cls_r.dv_zero) begin
      go_down = cls_r.di_pos;
      go_up   = !cls_r.di_pos && !cls_r.di_zero;
    end else if (cls_r.dv_pos) begin
      go_down = sum_pos;
      go_up   = sum_neg;
    end else begin
      go_down = sum_neg;
      go_up   = sum_pos;
    end
    if (cfg.tracking_mode) begin
      move_nxt = (dp_pos_r != cls_r.dv_pos) ? mdt_pkg::MOVE_UP : mdt_pkg::MOVE_DOWN;
    end else if (go_down) begin
      move_nxt = mdt_pkg::MOVE_DOWN;
    end else if (go_up) begin
      move_nxt = mdt_pkg::MOVE_UP;
    end else begin
      move_nxt = mdt_pkg::MOVE_HOLD;
    end
  end

  assign base    = STEP_W'(duty_now_r);
  assign step    = STEP_W'(cfg.duty_step);
  assign ceil_s  = STEP_W'(cfg.duty_ceiling);
  assign floor_s = STEP_W'(cfg.duty_floor);

  always_comb begin
    case (move_r)
      mdt_pkg::MOVE_UP:   stepped = base + step;
      mdt_pkg::MOVE_DOWN: stepped = base - step;
      default:            stepped = base;
    endcase
    if (stepped >= ceil_s) begin
      duty_nxt = cfg.duty_ceiling;
    end else if (stepped <= floor_s) begin
      duty_nxt = cfg.duty_floor;
    end else begin
      duty_nxt = stepped[mdt_pkg::DUTY_W-1:0];
    end
  end

  assign out_result.duty_count    = prod_r[mdt_pkg::FRAC_BITS +: mdt_pkg::PERIOD_W];
  assign out_result.duty_fraction = duty_now_r;
  assign out_result.move          = move_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mdt_pkg::BK_IDLE;
      duty_now_r <= '0;
      last_pwr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mdt_pkg::BK_DECIDE) begin
        last_pwr_r <= pwr_r;
      end
      if (state_r == mdt_pkg::BK_STEP) begin
        duty_now_r <= duty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      volt_r <= q_rdata[VOLT_LSB +: VOLT_W];
      curr_r <= q_rdata[CURR_LSB +: CURR_W];
      dv_r   <= q_rdata[DV_LSB +: DV_W];
      di_r   <= q_rdata[DI_LSB +: DI_W];
      cls_r  <= mdt_pkg::delta_class_t'(q_rdata[CLS_W-1:0]);
    end
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
    if (state_r == mdt_pkg::BK_MUL_A) begin
      pwr_r <= prod_r[POW_W-1:0];
    end
    if (state_r == mdt_pkg::BK_MUL_B) begin
      acc_r    <= prod_r;
      dp_pos_r <= dp_pos;
    end
    if (state_r == mdt_pkg::BK_DECIDE) begin
      move_r <= move_nxt;
    end
  end

endmodule

// File: hdl/mppt_duty_tracker.sv
// MPPT duty tracker top level: configuration registers, queues and the two engines.
//
// Input side is a queue: drive in_push with a voltage/current ADC pair while in_full
// is low. Results come out of a queue: while out_empty is low the oldest result
// (duty_count, duty_fraction, move) sits on the out_ ports; out_pop takes it.
// Configuration writes go through cfg_valid/cfg_ready (always ready) with a
// register index and data; indexes past the last register are dropped. Write
// only while no item is in flight.
// From input accept to the out_ ports an item passes two front stages, the middle
// queue, the eight back sequencer states and the result queue. The back sequencer
// takes a new item only after it has emitted the last one, since it runs power,
// two cross products and the PWM count through one shared multiplier.
// Reset loads the default register values, zeroes duty and the stored
// voltage, current and power, and empties both queues.
// When the receiver stalls, the result queue fills with QUEUE_DEPTH items, the back end
// waits in its last state, the middle queue fills and in_full then rises.
`timescale 1ns / 1ps
`include "mppt_duty_tracker_defines.svh"

module mppt_duty_tracker #(
  parameter int ADC_BITS    = mdt_pkg::ADC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = mdt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [ADC_BITS-1:0]                in_voltage_code,
  input  logic [ADC_BITS-1:0]                in_current_code,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [mdt_pkg::PERIOD_W-1:0]       out_duty_count,
  output logic [mdt_pkg::DUTY_W-1:0]         out_duty_fraction,
  output logic [1:0]                         out_move,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ENTRY_W = mdt_pkg::entry_w(ADC_BITS);
  localparam int RES_W   = $bits(mdt_pkg::result_t);

  mdt_pkg::cfg_t     cfg_r, cfg_nxt;
  logic              mid_push, mid_pop, mid_full, mid_empty;
  logic [ENTRY_W-1:0] mid_wdata, mid_rdata;
  logic              out_push, out_full;
  mdt_pkg::result_t  back_result, out_result;
  logic [RES_W-1:0]  out_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mdt_pkg::CFG_TRACKING_MODE:  cfg_nxt.tracking_mode  = cfg_data[0];
        mdt_pkg::CFG_VOLTAGE_GAIN:   cfg_nxt.voltage_gain   = cfg_data[mdt_pkg::GAIN_W-1:0];
        mdt_pkg::CFG_CURRENT_GAIN:   cfg_nxt.current_gain   = cfg_data[mdt_pkg::GAIN_W-1:0];
        mdt_pkg::CFG_CURRENT_OFFSET: cfg_nxt.current_offset = cfg_data[mdt_pkg::OFFSET_W-1:0];
        mdt_pkg::CFG_DUTY_STEP:      cfg_nxt.duty_step      = cfg_data[mdt_pkg::DUTY_W-1:0];
        mdt_pkg::CFG_DUTY_CEILING:   cfg_nxt.duty_ceiling   = cfg_data[mdt_pkg::DUTY_W-1:0];
        mdt_pkg::CFG_DUTY_FLOOR:     cfg_nxt.duty_floor     = cfg_data[mdt_pkg::DUTY_W-1:0];
        mdt_pkg::CFG_PWM_PERIOD:     cfg_nxt.pwm_period     = cfg_data[mdt_pkg::PERIOD_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mdt_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mdt_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_voltage_code (in_voltage_code),
    .in_current_code (in_current_code),
    .q_full          (mid_full),
    .q_push          (mid_push),
    .q_wdata         (mid_wdata)
  );

  mdt_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  mdt_back #(
    .ADC_BITS (ADC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (mid_empty),
    .q_pop      (mid_pop),
    .q_rdata    (mid_rdata),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_result (back_result)
  );

  mdt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (back_result),
    .pop   (out_pop),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (out_empty)
  );

  assign out_result        = mdt_pkg::result_t'(out_rdata);
  assign out_duty_count    = out_result.duty_count;
  assign out_duty_fraction = out_result.duty_fraction;
  assign out_move          = out_result.move;

  `MDT_ASSERT_IMP(a_mid_push_room, clk, rst_n, mid_push, !mid_full)
  `MDT_ASSERT_IMP(a_mid_pop_data, clk, rst_n, mid_pop, !mid_empty)
  `MDT_ASSERT_IMP(a_out_push_room, clk, rst_n, out_push, !out_full)
  `MDT_ASSERT_NEXT(a_out_push_shows, clk, rst_n, out_push, !out_empty)

endmodule

// File: sim/mppt_duty_checker.sv
// Checker for the MPPT duty tracker: follows register writes, predicts each result, compares.
`timescale 1ns / 1ps

module mppt_duty_checker
  import mdt_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  logic [ADC_BITS-1:0]    in_voltage_code,
  input  logic [ADC_BITS-1:0]    in_current_code,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  logic [PERIOD_W-1:0]    out_duty_count,
  input  logic [DUTY_W-1:0]      out_duty_fraction,
  input  logic [1:0]             out_move,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     results_owed
);

  cfg_t              regs;
  logic [DUTY_W-1:0] duty_now;
  longint            last_voltage;
  longint            last_current;
  longint            last_power;
  result_t           pending_duty[$];
  result_t           oldest;

  function automatic int polarity(input longint x);
    return int'(x > 0) - int'(x < 0);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void predict_duty(input logic [ADC_BITS-1:0] vc,
                                       input logic [ADC_BITS-1:0] ic);
    longint  v, i, p, dv, di, dp, t, duty, step, lim_hi, lim_lo;
    int      s;
    move_t   mv;
    result_t r;
    v = vc;
    t = regs.voltage_gain;
    v = v * t;
    i = regs.current_offset;
    t = ic;
    p = regs.current_gain;
    i = i - t * p;
    p = v * i;
    dv = v - last_voltage;
    di = i - last_current;
    dp = p - last_power;
    if (!regs.tracking_mode) begin
      if (dv == 0)
        s = polarity(di);
      else
        s = polarity(di * v + i * dv) * polarity(dv);
      mv = (s > 0) ? MOVE_DOWN : ((s < 0) ? MOVE_UP : MOVE_HOLD);
    end else begin
      mv = ((dp > 0) != (dv > 0)) ? MOVE_UP : MOVE_DOWN;
    end
    duty = duty_now;
    step = regs.duty_step;
    if (mv == MOVE_UP)
      duty = duty + step;
    else if (mv == MOVE_DOWN)
      duty = duty - step;
    lim_hi = regs.duty_ceiling;
    lim_lo = regs.duty_floor;
    if (duty >= lim_hi)
      duty = lim_hi;
    else if (duty <= lim_lo)
      duty = lim_lo;
    duty_now = duty[DUTY_W-1:0];
    last_voltage = v;
    last_current = i;
    last_power = p;
    t = regs.pwm_period;
    t = (t * duty_now) >>> FRAC_BITS;
    r.duty_count = t[PERIOD_W-1:0];
    r.duty_fraction = duty_now;
    r.move = mv;
    pending_duty.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = CFG_RESET;
      duty_now = '0;
      last_voltage = 0;
      last_current = 0;
      last_power = 0;
      pending_duty.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRACKING_MODE:  regs.tracking_mode = cfg_data[0];
          CFG_VOLTAGE_GAIN:   regs.voltage_gain = cfg_data[GAIN_W-1:0];
          CFG_CURRENT_GAIN:   regs.current_gain = cfg_data[GAIN_W-1:0];
          CFG_CURRENT_OFFSET: regs.current_offset = cfg_data[OFFSET_W-1:0];
          CFG_DUTY_STEP:      regs.duty_step = cfg_data[DUTY_W-1:0];
          CFG_DUTY_CEILING:   regs.duty_ceiling = cfg_data[DUTY_W-1:0];
          CFG_DUTY_FLOOR:     regs.duty_floor = cfg_data[DUTY_W-1:0];
          CFG_PWM_PERIOD:     regs.pwm_period = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (pending_duty.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          oldest = pending_duty.pop_front();
          if (out_duty_count !== oldest.duty_count)
            report_mismatch($sformatf("duty_count got %0d want %0d",
                                      out_duty_count, oldest.duty_count));
          if (out_duty_fraction !== oldest.duty_fraction)
            report_mismatch($sformatf("duty_fraction got %0d want %0d",
                                      out_duty_fraction, oldest.duty_fraction));
          if (out_move !== oldest.move)
            report_mismatch($sformatf("move got %0d want %0d", out_move, oldest.move));
        end
      end
      if (in_push && !in_full)
        predict_duty(in_voltage_code, in_current_code);
    end
    results_owed = pending_duty.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for the MPPT duty tracker: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb;
  import mdt_pkg::*;

  localparam int ADC_W       = ADC_BITS_DEFAULT;
  localparam int ADC_MAX     = (1 << ADC_W) - 1;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int SPARE_INDEX = int'(CFG_PWM_PERIOD) + 1;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 180;

  typedef enum int {
    REGS_ALL_ONES,
    REGS_ALL_ZERO,
    REGS_RANDOM
  } regs_kind_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_push;
  logic                   in_full;
  logic [ADC_W-1:0]       in_voltage_code;
  logic [ADC_W-1:0]       in_current_code;
  logic                   out_empty;
  logic                   out_pop;
  logic [PERIOD_W-1:0]    out_duty_count;
  logic [DUTY_W-1:0]      out_duty_fraction;
  logic [1:0]             out_move;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int results_owed;
  int cycle_count   = 0;
  int push_idle_pct = 0;
  int pop_stall_pct = 0;
  int pop_hold      = 0;

  always #10 clk = ~clk;

  mppt_duty_tracker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_voltage_code   (in_voltage_code),
    .in_current_code   (in_current_code),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_duty_count    (out_duty_count),
    .out_duty_fraction (out_duty_fraction),
    .out_move          (out_move),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  mppt_duty_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_voltage_code   (in_voltage_code),
    .in_current_code   (in_current_code),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_duty_count    (out_duty_count),
    .out_duty_fraction (out_duty_fraction),
    .out_move          (out_move),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .results_owed      (results_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_value(input int w);
    int unsigned mask;
    mask = (1 << w) - 1;
    case ($urandom_range(0, 7))
      0: return 0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic cfg_t random_regs(input regs_kind_t kind);
    cfg_t c;
    case (kind)
      REGS_ALL_ONES: c = '1;
      REGS_ALL_ZERO: c = '0;
      default: begin
        c.voltage_gain = GAIN_W'(pick_value(GAIN_W));
        c.current_gain = GAIN_W'(pick_value(GAIN_W));
        c.current_offset = OFFSET_W'(pick_value(OFFSET_W));
        c.duty_step = DUTY_W'($urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                   : pick_value(DUTY_W));
        if ($urandom_range(0, 3) != 0) begin
          c.duty_ceiling = DUTY_W'($urandom_range(32768, 65535));
          c.duty_floor = DUTY_W'($urandom_range(0, 32767));
        end else begin
          c.duty_ceiling = DUTY_W'(pick_value(DUTY_W));
          c.duty_floor = DUTY_W'(pick_value(DUTY_W));
        end
        c.pwm_period = PERIOD_W'(pick_value(PERIOD_W));
      end
    endcase
    c.tracking_mode = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // hold valid and the fields until the write is taken; upper data bits carry junk
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val,
                           input int w);
    logic [63:0] word;
    word = {$urandom, $urandom};
    word = (word << w) | 64'(val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(CFG_TRACKING_MODE, c.tracking_mode, 1);
    write_reg(CFG_VOLTAGE_GAIN, c.voltage_gain, GAIN_W);
    write_reg(CFG_CURRENT_GAIN, c.current_gain, GAIN_W);
    write_reg(CFG_CURRENT_OFFSET, c.current_offset, OFFSET_W);
    write_reg(CFG_DUTY_STEP, c.duty_step, DUTY_W);
    write_reg(CFG_DUTY_CEILING, c.duty_ceiling, DUTY_W);
    write_reg(CFG_DUTY_FLOOR, c.duty_floor, DUTY_W);
    write_reg(CFG_PWM_PERIOD, c.pwm_period, PERIOD_W);
    write_reg(CFG_INDEX_W'($urandom_range(SPARE_INDEX, (1 << CFG_INDEX_W) - 1)), $urandom, 0);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input int vc, input int ic);
    in_push <= 1'b1;
    in_voltage_code <= ADC_W'(vc);
    in_current_code <= ADC_W'(ic);
    do @(posedge clk); while (in_full);
    if ($urandom_range(0, 99) < push_idle_pct) begin
      in_push <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  function automatic int nudge(input int x);
    int y;
    y = x + $urandom_range(0, 6) - 3;
    return (y < 0) ? 0 : ((y > ADC_MAX) ? ADC_MAX : y);
  endfunction

  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop_hold != 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 99) < pop_stall_pct)
          pop_hold = gap_len();
      end
    end
  end

  initial begin
    cfg_t regs;
    int   cv;
    int   ci;
    int   roll;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_voltage_code <= '0;
    in_current_code <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_idle_pct = 30;
    pop_stall_pct = 30;
    send_sample(0, 0);
    send_sample(ADC_MAX, 0);
    send_sample(ADC_MAX, 0);
    send_sample(ADC_MAX, ADC_MAX);
    send_sample(0, ADC_MAX);
    send_sample(512, 512);
    send_sample(600, 512);
    send_sample(600, 400);
    wait_drained();

    write_reg(CFG_TRACKING_MODE, 1, 1);
    cfg_valid <= 1'b0;
    send_sample(600, 400);
    send_sample(700, 400);
    send_sample(800, ADC_MAX);
    send_sample(100, 0);
    send_sample(50, 1000);
    wait_drained();

    regs = CFG_RESET;
    regs.duty_ceiling = DUTY_W'(1000);
    regs.duty_floor = DUTY_W'(5000);
    regs.duty_step = DUTY_W'(700);
    regs.pwm_period = PERIOD_W'(1023);
    load_regs(regs);
    send_sample(300, 200);
    send_sample(300, 200);
    send_sample(301, 200);
    send_sample(0, 0);
    wait_drained();

    load_regs(random_regs(REGS_ALL_ONES));
    send_sample(ADC_MAX, ADC_MAX);
    send_sample(0, 0);
    send_sample(ADC_MAX, 0);
    send_sample(0, ADC_MAX);
    wait_drained();

    load_regs(random_regs(REGS_ALL_ZERO));
    send_sample(ADC_MAX, ADC_MAX);
    send_sample(0, 0);
    wait_drained();

    cv = $urandom_range(0, ADC_MAX);
    ci = $urandom_range(0, ADC_MAX);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        regs = random_regs(REGS_ALL_ONES);
      else if (ph == 1)
        regs = random_regs(REGS_ALL_ZERO);
      else
        regs = random_regs(REGS_RANDOM);
      load_regs(regs);
      push_idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      pop_stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2)
          wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          cv = nudge(cv);
          ci = nudge(ci);
        end else if (roll < 75) begin
        end else if (roll < 85) begin
          ci = nudge(ci);
        end else begin
          cv = $urandom_range(0, ADC_MAX);
          ci = $urandom_range(0, ADC_MAX);
        end
        send_sample(cv, ci);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
